@@ rtl/core/wthf_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Shared types, constants and width helpers for the waveform threshold hit finder.
// No dependencies; used by every module of the block except wthf_queue.

package wthf_pkg;

    // Configuration register file, one member per register
    typedef struct packed {
        logic [15:0] baseline_q4;
        logic [15:0] rms_q4;
        logic [7:0]  nsigma_q4;
        logic [4:0]  side_ticks;
        logic [13:0] min_width;
        logic [13:0] waveform_length;
    } cfg_t;

    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BASELINE  = 3'd0,
        REG_RMS       = 3'd1,
        REG_NSIGMA    = 3'd2,
        REG_SIDE      = 3'd3,
        REG_MIN_WIDTH = 3'd4,
        REG_LENGTH    = 3'd5
    } reg_idx_t;

    localparam logic [15:0] RST_BASELINE  = 16'd0;
    localparam logic [15:0] RST_RMS       = 16'd16;
    localparam logic [7:0]  RST_NSIGMA    = 8'd48;
    localparam logic [4:0]  RST_SIDE      = 5'd0;
    localparam logic [13:0] RST_MIN_WIDTH = 14'd0;
    localparam logic [13:0] RST_LENGTH    = 14'd8192;

    // Result field widths
    localparam int AMP_OUT_W  = 16;
    localparam int AREA_OUT_W = 30;
    localparam int TICK_OUT_W = 13;

    // Area saturation bound
    localparam logic signed [31:0] AREA_LIMIT = 32'sd536870911;

    // Per-tick classification flags carried from front to back
    typedef struct packed {
        logic examine;  // tick lies inside the examined window
        logic above;    // height above threshold
        logic last;     // last tick of the waveform
    } rec_ctl_t;

    // Signed height above baseline, 12.4 style
    function automatic int hgt_w(int adc_bits);
        return ((adc_bits + 4 > 16) ? adc_bits + 4 : 16) + 1;
    endfunction

    function automatic int side_cnt_w(int max_side);
        return $clog2(max_side + 1);
    endfunction

    // Signed sum of side heights
    function automatic int side_w(int adc_bits, int max_side);
        return hgt_w(adc_bits) + side_cnt_w(max_side) + 1;
    endfunction

    function automatic int tick_w(int max_len);
        return $clog2(max_len);
    endfunction

    function automatic int len_w(int max_len);
        return $clog2(max_len + 1);
    endfunction

    // Side taps are pre-summed in groups of four
    function automatic int grp_n(int max_side);
        return (max_side + 3) >> 2;
    endfunction

    function automatic int grp_w(int adc_bits);
        return adc_bits + 2;
    endfunction

    function automatic int sum_w(int adc_bits, int max_side);
        return adc_bits + side_cnt_w(max_side);
    endfunction

    // side count times baseline
    function automatic int sbase_w(int max_side);
        return 16 + side_cnt_w(max_side);
    endfunction

    function automatic int area_w(int adc_bits, int max_len);
        return hgt_w(adc_bits) + tick_w(max_len) + 1;
    endfunction

    function automatic int tot_w(int adc_bits, int max_len);
        return (area_w(adc_bits, max_len) + 2 > 32) ? area_w(adc_bits, max_len) + 2 : 32;
    endfunction

    // Width of one queued tick record
    function automatic int rec_w(int adc_bits, int max_side, int max_len);
        return $bits(rec_ctl_t) + tick_w(max_len) + hgt_w(adc_bits)
               + 2 * grp_n(max_side) * grp_w(adc_bits) + sbase_w(max_side);
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/wthf_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Two-entry record queue between the front and back halves of the hit finder.
// Generic width; no package dependency.

module wthf_queue #(
    parameter int WIDTH = 64
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    output logic                  pop_valid,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      pop_data
);

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_data  = slot_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/wthf_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Front half: sample delay line, tick counter and per-tick classification.
// Depends on wthf_pkg; pushes one record per input transfer into wthf_queue.

module wthf_front #(
    parameter int MAX_SIDE  = 16,
    parameter int EDGE_SKIP = 50,
    parameter int MAX_LEN   = 8192,
    parameter int ADC_BITS  = 12
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire wthf_pkg::cfg_t       cfg,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [ADC_BITS-1:0]  s_adc_sample,
    input  wire logic                 q_full,
    output logic                      push,
    output logic [wthf_pkg::rec_w(ADC_BITS, MAX_SIDE, MAX_LEN)-1:0] push_data
);

    localparam int HGT_W      = wthf_pkg::hgt_w(ADC_BITS);
    localparam int TICK_W     = wthf_pkg::tick_w(MAX_LEN);
    localparam int LEN_W      = wthf_pkg::len_w(MAX_LEN);
    localparam int GRP_N      = wthf_pkg::grp_n(MAX_SIDE);
    localparam int GRP_W      = wthf_pkg::grp_w(ADC_BITS);
    localparam int SBASE_W    = wthf_pkg::sbase_w(MAX_SIDE);
    localparam int SIDE_CNT_W = wthf_pkg::side_cnt_w(MAX_SIDE);
    localparam int WIN_DEPTH  = 2 * MAX_SIDE;

    typedef struct packed {
        wthf_pkg::rec_ctl_t               ctl;
        logic [TICK_W-1:0]                tick;
        logic signed [HGT_W-1:0]          height;
        logic [GRP_N-1:0][GRP_W-1:0]      behind_grp;
        logic [GRP_N-1:0][GRP_W-1:0]      ahead_grp;
        logic [SBASE_W-1:0]               side_base;
    } rec_t;

    logic [ADC_BITS-1:0]         window_reg [WIN_DEPTH];
    logic [TICK_W-1:0]           count_reg, count_next;
    logic [LEN_W-1:0]            len_eff;
    logic [LEN_W-1:0]            count_inc;
    logic [SIDE_CNT_W-1:0]       side_eff;
    logic [23:0]                 thr;
    logic signed [HGT_W-1:0]     height;
    logic [HGT_W+3:0]            height_x16;
    logic                        tick_last;
    logic                        tick_examine;
    logic                        tick_above;
    logic [TICK_W-1:0]           exam_tick;
    logic [SBASE_W-1:0]          side_base;
    logic [GRP_N-1:0][GRP_W-1:0] behind_grp;
    logic [GRP_N-1:0][GRP_W-1:0] ahead_grp;
    rec_t                        rec;

    assign s_ready   = !q_full;
    assign push      = s_valid && !q_full;
    assign push_data = rec;

    // waveform length clamp and end-of-waveform detect
    always_comb begin
        if (cfg.waveform_length == '0) begin
            len_eff = LEN_W'(1);
        end else if (32'(cfg.waveform_length) > 32'(MAX_LEN)) begin
            len_eff = LEN_W'(MAX_LEN);
        end else begin
            len_eff = LEN_W'(cfg.waveform_length);
        end
        count_inc  = LEN_W'(count_reg) + LEN_W'(1);
        tick_last  = (count_inc >= len_eff);
        count_next = tick_last ? '0 : TICK_W'(count_inc);
    end

    // examined tick is MAX_SIDE behind the newest sample
    always_comb begin
        tick_examine = (32'(count_reg) >= 32'(MAX_SIDE + EDGE_SKIP))
                    && (32'(count_reg) + 32'(EDGE_SKIP) < 32'(len_eff) + 32'(MAX_SIDE));
        exam_tick  = count_reg - TICK_W'(MAX_SIDE);
        height     = $signed(HGT_W'({window_reg[MAX_SIDE-1], 4'b0000}))
                   - $signed(HGT_W'(cfg.baseline_q4));
        // threshold compare with 8 fractional bits on both sides
        thr        = cfg.rms_q4 * 24'(cfg.nsigma_q4);
        height_x16 = {height, 4'b0000};
        tick_above = !height[HGT_W-1] && (32'(height_x16) > 32'(thr));
    end

    // side tick count and its baseline share
    always_comb begin
        if (32'(cfg.side_ticks) > 32'(MAX_SIDE)) begin
            side_eff = SIDE_CNT_W'(MAX_SIDE);
        end else begin
            side_eff = SIDE_CNT_W'(cfg.side_ticks);
        end
        side_base = SBASE_W'(side_eff) * SBASE_W'(cfg.baseline_q4);
    end

    // masked side taps, pre-summed in groups of four
    always_comb begin
        int j;
        int bi;
        int ai;
        for (int g = 0; g < GRP_N; g++) begin
            behind_grp[g] = '0;
            ahead_grp[g]  = '0;
            for (int k = 0; k < 4; k++) begin
                j  = 4 * g + k;
                bi = (j < MAX_SIDE) ? MAX_SIDE + j : 0;
                ai = (j < MAX_SIDE) ? MAX_SIDE - 1 - j : 0;
                if (j < MAX_SIDE && j < int'(side_eff)) begin
                    behind_grp[g] = behind_grp[g] + GRP_W'(window_reg[bi]);
                    ahead_grp[g]  = ahead_grp[g] + GRP_W'(window_reg[ai]);
                end
            end
        end
    end

    // record for the queue
    always_comb begin
        rec.ctl.examine = tick_examine;
        rec.ctl.above   = tick_above;
        rec.ctl.last    = tick_last;
        rec.tick        = exam_tick;
        rec.height      = height;
        rec.behind_grp  = behind_grp;
        rec.ahead_grp   = ahead_grp;
        rec.side_base   = side_base;
    end

    // delay line and tick counter; both clear at waveform end
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            for (int k = 0; k < WIN_DEPTH; k++) begin
                window_reg[k] <= '0;
            end
        end else if (push) begin
            count_reg <= count_next;
            if (tick_last) begin
                for (int k = 0; k < WIN_DEPTH; k++) begin
                    window_reg[k] <= '0;
                end
            end else begin
                window_reg[0] <= s_adc_sample;
                for (int k = 1; k < WIN_DEPTH; k++) begin
                    window_reg[k] <= window_reg[k-1];
                end
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/wthf_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Back half: hit tracking (peak, area, start) and the result output register.
// Depends on wthf_pkg; consumes records from wthf_queue.

module wthf_back #(
    parameter int MAX_SIDE  = 16,
    parameter int MAX_LEN   = 8192,
    parameter int ADC_BITS  = 12
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire wthf_pkg::cfg_t   cfg,
    input  wire logic             rec_valid,
    output logic                  rec_ready,
    input  wire logic [wthf_pkg::rec_w(ADC_BITS, MAX_SIDE, MAX_LEN)-1:0] rec_data,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic [wthf_pkg::AMP_OUT_W-1:0]         m_hit_amplitude,
    output logic signed [wthf_pkg::AREA_OUT_W-1:0] m_hit_area,
    output logic [wthf_pkg::TICK_OUT_W-1:0]        m_peak_tick,
    output logic [wthf_pkg::TICK_OUT_W-1:0]        m_start_tick,
    output logic [wthf_pkg::TICK_OUT_W-1:0]        m_end_tick
);

    localparam int HGT_W   = wthf_pkg::hgt_w(ADC_BITS);
    localparam int TICK_W  = wthf_pkg::tick_w(MAX_LEN);
    localparam int GRP_N   = wthf_pkg::grp_n(MAX_SIDE);
    localparam int GRP_W   = wthf_pkg::grp_w(ADC_BITS);
    localparam int SBASE_W = wthf_pkg::sbase_w(MAX_SIDE);
    localparam int SIDE_W  = wthf_pkg::side_w(ADC_BITS, MAX_SIDE);
    localparam int SUM_W   = wthf_pkg::sum_w(ADC_BITS, MAX_SIDE);
    localparam int AREA_W  = wthf_pkg::area_w(ADC_BITS, MAX_LEN);
    localparam int TOT_W   = wthf_pkg::tot_w(ADC_BITS, MAX_LEN);

    localparam logic signed [TOT_W-1:0] LIM_POS = TOT_W'(wthf_pkg::AREA_LIMIT);
    localparam logic signed [TOT_W-1:0] LIM_NEG = -LIM_POS;

    typedef struct packed {
        wthf_pkg::rec_ctl_t               ctl;
        logic [TICK_W-1:0]                tick;
        logic signed [HGT_W-1:0]          height;
        logic [GRP_N-1:0][GRP_W-1:0]      behind_grp;
        logic [GRP_N-1:0][GRP_W-1:0]      ahead_grp;
        logic [SBASE_W-1:0]               side_base;
    } rec_t;

    rec_t rec;

    logic                     in_hit_reg, in_hit_next;
    logic signed [HGT_W-1:0]  peak_reg, peak_next;
    logic signed [AREA_W-1:0] area_reg, area_next;
    logic signed [SIDE_W-1:0] behind_reg, behind_next;
    logic [TICK_W-1:0]        peak_idx_reg, peak_idx_next;
    logic [TICK_W-1:0]        start_reg, start_next;

    logic                     out_valid_reg, out_valid_next;
    logic [wthf_pkg::AMP_OUT_W-1:0]         amp_reg, amp_next;
    logic signed [wthf_pkg::AREA_OUT_W-1:0] area_out_reg, area_out_next;
    logic [wthf_pkg::TICK_OUT_W-1:0]        peak_out_reg, peak_out_next;
    logic [wthf_pkg::TICK_OUT_W-1:0]        start_out_reg, start_out_next;
    logic [wthf_pkg::TICK_OUT_W-1:0]        end_out_reg, end_out_next;

    logic [SUM_W-1:0]         behind_total, ahead_total;
    logic signed [SIDE_W-1:0] behind_h, ahead_h;
    logic signed [TOT_W-1:0]  total, total_sat;
    logic                     pop, emit, width_ok;

    assign rec       = rec_t'(rec_data);
    assign rec_ready = !out_valid_reg || m_ready;
    assign pop       = rec_valid && rec_ready;

    assign m_valid         = out_valid_reg;
    assign m_hit_amplitude = amp_reg;
    assign m_hit_area      = area_out_reg;
    assign m_peak_tick     = peak_out_reg;
    assign m_start_tick    = start_out_reg;
    assign m_end_tick      = end_out_reg;

    // side heights: finish the group sums, remove the baseline share
    always_comb begin
        behind_total = '0;
        ahead_total  = '0;
        for (int g = 0; g < GRP_N; g++) begin
            behind_total = behind_total + SUM_W'(rec.behind_grp[g]);
            ahead_total  = ahead_total + SUM_W'(rec.ahead_grp[g]);
        end
        behind_h = $signed(SIDE_W'({behind_total, 4'b0000})) - $signed(SIDE_W'(rec.side_base));
        ahead_h  = $signed(SIDE_W'({ahead_total, 4'b0000})) - $signed(SIDE_W'(rec.side_base));
    end

    // closing area with saturation
    always_comb begin
        total = TOT_W'(area_reg) + TOT_W'(behind_reg) + TOT_W'(ahead_h);
        if (total > LIM_POS) begin
            total_sat = LIM_POS;
        end else if (total < LIM_NEG) begin
            total_sat = LIM_NEG;
        end else begin
            total_sat = total;
        end
        width_ok = (32'(rec.tick - start_reg) >= 32'(cfg.min_width));
    end

    // hit tracking
    always_comb begin
        in_hit_next   = in_hit_reg;
        peak_next     = peak_reg;
        area_next     = area_reg;
        behind_next   = behind_reg;
        peak_idx_next = peak_idx_reg;
        start_next    = start_reg;
        emit          = 1'b0;
        if (pop) begin
            if (rec.ctl.examine) begin
                if (rec.ctl.above) begin
                    if (!in_hit_reg) begin
                        in_hit_next   = 1'b1;
                        peak_next     = rec.height;
                        area_next     = AREA_W'(rec.height);
                        behind_next   = behind_h;
                        peak_idx_next = rec.tick;
                        start_next    = rec.tick;
                    end else begin
                        area_next = area_reg + AREA_W'(rec.height);
                        if (rec.height > peak_reg) begin
                            peak_next     = rec.height;
                            peak_idx_next = rec.tick;
                        end
                    end
                end else if (in_hit_reg) begin
                    emit        = width_ok;
                    in_hit_next = 1'b0;
                end
            end
            // waveform end drops an open hit
            if (rec.ctl.last) begin
                in_hit_next = 1'b0;
            end
        end
    end

    // result register
    always_comb begin
        out_valid_next = out_valid_reg;
        amp_next       = amp_reg;
        area_out_next  = area_out_reg;
        peak_out_next  = peak_out_reg;
        start_out_next = start_out_reg;
        end_out_next   = end_out_reg;
        if (emit) begin
            out_valid_next = 1'b1;
            amp_next       = wthf_pkg::AMP_OUT_W'(peak_reg);
            area_out_next  = wthf_pkg::AREA_OUT_W'(total_sat);
            peak_out_next  = wthf_pkg::TICK_OUT_W'(peak_idx_reg);
            start_out_next = wthf_pkg::TICK_OUT_W'(start_reg);
            end_out_next   = wthf_pkg::TICK_OUT_W'(rec.tick);
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_hit_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_hit_reg    <= in_hit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        peak_reg      <= peak_next;
        area_reg      <= area_next;
        behind_reg    <= behind_next;
        peak_idx_reg  <= peak_idx_next;
        start_reg     <= start_next;
        amp_reg       <= amp_next;
        area_out_reg  <= area_out_next;
        peak_out_reg  <= peak_out_next;
        start_out_reg <= start_out_next;
        end_out_reg   <= end_out_next;
    end

endmodule

`default_nettype wire

@@ rtl/core/waveform_threshold_hit_finder.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Waveform threshold hit finder, top level: config registers, front, queue, back.
// Throughput: one sample per cycle; a stalled result fills the 2-entry queue and drops s_ready.
// A hit closes with the sample of tick end_tick+MAX_SIDE (delay line depth); m_valid
// rises once that record has passed the queue entry and then the result register, when the queue was empty.
// Reset (aresetn low, synchronous) restores register defaults and clears delay line,
// tick count, queue, open hit and the result register.

module waveform_threshold_hit_finder #(
    parameter int MAX_SIDE  = 16,
    parameter int EDGE_SKIP = 50,
    parameter int MAX_LEN   = 8192,
    parameter int ADC_BITS  = 12
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   cfg_wr_en,
    input  wire logic [wthf_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [wthf_pkg::CFG_DATA_W-1:0]        cfg_wdata,
    input  wire logic                                   s_valid,
    output logic                                        s_ready,
    input  wire logic [ADC_BITS-1:0]                    s_adc_sample,
    output logic                                        m_valid,
    input  wire logic                                   m_ready,
    output logic [wthf_pkg::AMP_OUT_W-1:0]              m_hit_amplitude,
    output logic signed [wthf_pkg::AREA_OUT_W-1:0]      m_hit_area,
    output logic [wthf_pkg::TICK_OUT_W-1:0]             m_peak_tick,
    output logic [wthf_pkg::TICK_OUT_W-1:0]             m_start_tick,
    output logic [wthf_pkg::TICK_OUT_W-1:0]             m_end_tick
);

    localparam int REC_W = wthf_pkg::rec_w(ADC_BITS, MAX_SIDE, MAX_LEN);

    wthf_pkg::cfg_t   cfg_reg, cfg_next;
    logic             q_full, q_push, q_valid, q_pop;
    logic             q_pop_ready;
    logic [REC_W-1:0] q_wdata, q_rdata;

    // configuration write decode
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (wthf_pkg::reg_idx_t'(cfg_index))
                wthf_pkg::REG_BASELINE:  cfg_next.baseline_q4     = cfg_wdata;
                wthf_pkg::REG_RMS:       cfg_next.rms_q4          = cfg_wdata;
                wthf_pkg::REG_NSIGMA:    cfg_next.nsigma_q4       = cfg_wdata[7:0];
                wthf_pkg::REG_SIDE:      cfg_next.side_ticks      = cfg_wdata[4:0];
                wthf_pkg::REG_MIN_WIDTH: cfg_next.min_width       = cfg_wdata[13:0];
                wthf_pkg::REG_LENGTH:    cfg_next.waveform_length = cfg_wdata[13:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.baseline_q4     <= wthf_pkg::RST_BASELINE;
            cfg_reg.rms_q4          <= wthf_pkg::RST_RMS;
            cfg_reg.nsigma_q4       <= wthf_pkg::RST_NSIGMA;
            cfg_reg.side_ticks      <= wthf_pkg::RST_SIDE;
            cfg_reg.min_width       <= wthf_pkg::RST_MIN_WIDTH;
            cfg_reg.waveform_length <= wthf_pkg::RST_LENGTH;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    wthf_front #(
        .MAX_SIDE  (MAX_SIDE),
        .EDGE_SKIP (EDGE_SKIP),
        .MAX_LEN   (MAX_LEN),
        .ADC_BITS  (ADC_BITS)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg_reg),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_adc_sample (s_adc_sample),
        .q_full       (q_full),
        .push         (q_push),
        .push_data    (q_wdata)
    );

    wthf_queue #(
        .WIDTH (REC_W)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_wdata),
        .full      (q_full),
        .pop_valid (q_valid),
        .pop       (q_pop),
        .pop_data  (q_rdata)
    );

    wthf_back #(
        .MAX_SIDE (MAX_SIDE),
        .MAX_LEN  (MAX_LEN),
        .ADC_BITS (ADC_BITS)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg_reg),
        .rec_valid       (q_valid),
        .rec_ready       (q_pop_ready),
        .rec_data        (q_rdata),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_hit_amplitude (m_hit_amplitude),
        .m_hit_area      (m_hit_area),
        .m_peak_tick     (m_peak_tick),
        .m_start_tick    (m_start_tick),
        .m_end_tick      (m_end_tick)
    );

    // queue pops when the back half takes a record
    assign q_pop = q_valid && q_pop_ready;

endmodule

`default_nettype wire

@@ rtl/core/wthf_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Port-level checker for the waveform threshold hit finder, with its bind.
// Depends on wthf_pkg for result widths; attaches to waveform_threshold_hit_finder.

module wthf_checker (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   m_valid,
    input  wire logic                                   m_ready,
    input  wire logic [wthf_pkg::AMP_OUT_W-1:0]         m_hit_amplitude,
    input  wire logic signed [wthf_pkg::AREA_OUT_W-1:0] m_hit_area,
    input  wire logic [wthf_pkg::TICK_OUT_W-1:0]        m_peak_tick,
    input  wire logic [wthf_pkg::TICK_OUT_W-1:0]        m_start_tick,
    input  wire logic [wthf_pkg::TICK_OUT_W-1:0]        m_end_tick
);

    // stalled result holds
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_hit_amplitude) && $stable(m_hit_area)
            && $stable(m_peak_tick) && $stable(m_start_tick) && $stable(m_end_tick))
        else $error("result changed while stalled");

    // reset empties the result register
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // peak lies inside the run, which ends after it starts
    a_tick_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_start_tick <= m_peak_tick) && (m_peak_tick < m_end_tick))
        else $error("hit ticks out of order");

    // saturated area never reaches the most negative code
    a_area_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_hit_area != {1'b1, {(wthf_pkg::AREA_OUT_W-1){1'b0}}})
        else $error("hit area beyond saturation bound");

endmodule

bind waveform_threshold_hit_finder wthf_checker u_wthf_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_hit_amplitude (m_hit_amplitude),
    .m_hit_area      (m_hit_area),
    .m_peak_tick     (m_peak_tick),
    .m_start_tick    (m_start_tick),
    .m_end_tick      (m_end_tick)
);

`default_nettype wire
